// ===== design/lcrc_pkg.sv =====
// Shared types and constants for the LEDBAT congestion and RTO controller.
package lcrc_pkg;

  // Command codes carried by each input transaction
  typedef enum logic [1:0] {
    CMD_DELAY   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_LOSS    = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WINDOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PKT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PKT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RTO_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RTO_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RTO  = 3'd5;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int PKT_W   = 16;
  localparam int RTT_W   = 26;
  localparam int FREED_W = 24;
  localparam int CFG_W   = 32;

  // Register defaults
  localparam logic [TIME_W-1:0] DEF_BASE_WINDOW = 32'd120000000;
  localparam logic [PKT_W-1:0]  DEF_PACKET      = 16'd1400;
  localparam logic [PKT_W-1:0]  DEF_MIN_PACKET  = 16'd150;
  localparam logic [RTT_W-1:0]  DEF_RTO_MIN     = 26'd500000;
  localparam logic [RTT_W-1:0]  DEF_RTO_MAX     = 26'd60000000;
  localparam logic [RTT_W-1:0]  DEF_INITIAL_RTO = 26'd1000000;
  localparam logic [TIME_W-1:0] RESET_WINDOW    = TIME_W'(DEF_PACKET) * 32'd2;

  // Queueing delay target, 100 ms
  localparam int OFF_W = 17;
  localparam logic [OFF_W-1:0] TARGET_US = 17'd100000;

  // Growth product and its division by the target:
  // 100000 = 2^5 * 3125, the odd part done by a reciprocal plus one correction
  localparam int PROD_W      = OFF_W + FREED_W;
  localparam int DIV_SHIFT   = 5;
  localparam int PQ_W        = PROD_W - DIV_SHIFT;
  localparam int DIV_ODD_W   = 12;
  localparam logic [DIV_ODD_W-1:0] DIV_ODD = 12'd3125;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP = 25'd21990232;
  localparam int RPROD_W     = PQ_W + RECIP_W;

endpackage

// ===== design/ledbat_congestion_rto_controller_top.sv =====
// LEDBAT congestion window and retransmission timeout controller, one connection.
//
// Usage: each input transaction carries a command (delay sample, ack of freed
// bytes, loss, timeout) plus the current in-flight bytes and peer window. Every
// input transaction yields exactly one output transaction holding the state
// after that command and the may_send flag.
// Configuration is written through cfg_we / cfg_index / cfg_data while no
// transaction is in flight; there is no read-back and no wait.
// An accepted transaction passes four pipeline stages (input register, growth
// multiplier, reciprocal multiplier, quotient correction) and then the output
// register, which raises out_valid. Throughput: one transaction per cycle while
// the receiver does not stall. Delay, RTT and payload state update in the first
// stage, window and RTO state in the output stage, so no hazard stalls occur.
// Reset (synchronous, active high) empties the pipeline, restores all
// configuration registers to their defaults and loads the connection state
// (window 2800 bytes, payload 1400, RTO 1 s, no RTT, no base delay).
// When the receiver stalls, the output register holds its transaction and
// bubbles ahead of it collapse; in_ready drops only once all four stages and
// the output register are full.
module ledbat_congestion_rto_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [lcrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcrc_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic [lcrc_pkg::TIME_W-1:0]    now_us,
  input  logic [lcrc_pkg::TIME_W-1:0]    delay_sample_us,
  input  logic [lcrc_pkg::FREED_W-1:0]   freed_bytes,
  input  logic                           rtt_valid,
  input  logic [lcrc_pkg::TIME_W-1:0]    rtt_sample_us,
  input  logic [lcrc_pkg::TIME_W-1:0]    in_flight_bytes,
  input  logic [lcrc_pkg::TIME_W-1:0]    peer_window,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lcrc_pkg::TIME_W-1:0]    window_bytes,
  output logic [lcrc_pkg::PKT_W-1:0]     payload_size,
  output logic [lcrc_pkg::RTT_W-1:0]     rto_us,
  output logic [lcrc_pkg::RTT_W-1:0]     smoothed_rtt_us,
  output logic [lcrc_pkg::RTT_W-1:0]     rtt_deviation_us,
  output logic [lcrc_pkg::TIME_W-1:0]    base_delay_us,
  output logic                           may_send
);

  localparam int TW = lcrc_pkg::TIME_W;
  localparam int PW = lcrc_pkg::PKT_W;
  localparam int RW = lcrc_pkg::RTT_W;
  localparam int FW = lcrc_pkg::FREED_W;
  localparam int XW = TW + 1;

  // Stage payload types
  typedef struct packed {
    lcrc_pkg::cmd_t  cmd;
    logic [TW-1:0]   now;
    logic [TW-1:0]   dsample;
    logic [FW-1:0]   freed;
    logic            rvalid;
    logic [TW-1:0]   rsample;
    logic [TW-1:0]   inflight;
    logic [TW-1:0]   peer;
  } in_stage_t;

  typedef struct packed {
    lcrc_pkg::cmd_t  cmd;
    logic            ack_go;
    logic            rtt_taken;
    logic [RW-1:0]   srtt;
    logic [RW-1:0]   rttvar;
    logic [PW-1:0]   pay;
    logic            base0;
    logic [TW-1:0]   base;
  } info_t;

  typedef struct packed {
    info_t                         info;
    logic [lcrc_pkg::PROD_W-1:0]   prod;
    logic [TW-1:0]                 inflight;
    logic [TW-1:0]                 peer;
  } mul_stage_t;

  typedef struct packed {
    info_t                         info;
    logic [lcrc_pkg::PQ_W-1:0]     pq;
    logic [FW-1:0]                 q0;
    logic [RW-1:0]                 rto_cand;
    logic [XW-1:0]                 xneed;
    logic                          peer_ok;
  } rcp_stage_t;

  typedef struct packed {
    info_t                         info;
    logic [FW-1:0]                 quot;
    logic [RW-1:0]                 rto_cand;
    logic [XW-1:0]                 xneed;
    logic                          peer_ok;
  } fix_stage_t;

  // Configuration registers
  logic [TW-1:0] cfg_base_window;
  logic [PW-1:0] cfg_default_pkt;
  logic [PW-1:0] cfg_min_pkt;
  logic [RW-1:0] cfg_rto_min;
  logic [RW-1:0] cfg_rto_max;

  // Pipeline registers and valids
  logic       v1, v2, v3, v4;
  in_stage_t  s1;
  mul_stage_t s2, s2_next;
  rcp_stage_t s3, s3_next;
  fix_stage_t s4, s4_next;

  // Front state: delay, RTT estimators, payload size
  logic [TW-1:0]              last_delay, base_delay, base_time;
  logic [lcrc_pkg::OFF_W-1:0] off_q;
  logic [RW-1:0]              srtt, rttvar;
  logic [PW-1:0]              pay_size;

  // Back state: window and RTO
  logic [TW-1:0] cong_window;
  logic [RW-1:0] rto_value;

  // Flow control
  logic free_out, free4, free3, free2, free1;
  logic go1, go4;

  assign free_out = !out_valid || out_ready;
  assign free4    = !v4 || free_out;
  assign free3    = !v3 || free4;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_ready = free1;
  assign go1      = v1 && free2;
  assign go4      = v4 && free_out;

  // ---------------------------------------------------------------- stage 1
  logic                       is_delay, ack_go, replace;
  logic [TW-1:0]              age, base_next, base_time_next, last_next, queue;
  logic [lcrc_pkg::OFF_W-1:0] off_next;
  logic                       rtt_take;
  logic [RW-1:0]              s26, dabs, var_upd, srtt_upd, srtt_next, rttvar_next;
  logic signed [RW:0]         var_err, var_bias, var_sum, rtt_err, rtt_bias, rtt_sum;
  logic [PW-1:0]              pay_next;

  assign is_delay = (s1.cmd == lcrc_pkg::CMD_DELAY);
  assign ack_go   = (s1.cmd == lcrc_pkg::CMD_ACK) && (s1.freed != '0);

  // Replace the base minimum when absent, beaten, or too old
  assign age     = s1.now - base_time;
  assign replace = (base_delay == '0) || (s1.dsample < base_delay) ||
                   (age > cfg_base_window);
  assign base_next      = (is_delay && replace) ? s1.dsample : base_delay;
  assign base_time_next = (is_delay && replace) ? s1.now : base_time;
  assign last_next      = is_delay ? s1.dsample : last_delay;

  // Keep the distance below target ready for the growth multiplier
  assign queue    = ((base_next != '0) && (last_next > base_next)) ?
                    (last_next - base_next) : '0;
  assign off_next = (queue >= TW'(lcrc_pkg::TARGET_US)) ? '0 :
                    (lcrc_pkg::TARGET_US - queue[lcrc_pkg::OFF_W-1:0]);

  // RTT estimators, divisions truncating toward zero
  assign rtt_take = ack_go && s1.rvalid && (s1.rsample != '0) &&
                    (s1.rsample <= TW'(cfg_rto_max));
  assign s26      = s1.rsample[RW-1:0];
  assign dabs     = (srtt >= s26) ? (srtt - s26) : (s26 - srtt);

  assign var_err  = $signed({1'b0, dabs}) - $signed({1'b0, rttvar});
  assign var_bias = var_err[RW] ? (var_err + (RW+1)'(3)) : var_err;
  assign var_sum  = $signed({1'b0, rttvar}) + (var_bias >>> 2);
  assign var_upd  = var_sum[RW-1:0];

  assign rtt_err  = $signed({1'b0, s26}) - $signed({1'b0, srtt});
  assign rtt_bias = rtt_err[RW] ? (rtt_err + (RW+1)'(7)) : rtt_err;
  assign rtt_sum  = $signed({1'b0, srtt}) + (rtt_bias >>> 3);
  assign srtt_upd = rtt_sum[RW-1:0];

  assign srtt_next   = !rtt_take ? srtt : ((srtt == '0) ? s26 : srtt_upd);
  assign rttvar_next = !rtt_take ? rttvar : ((srtt == '0) ? (s26 >> 1) : var_upd);

  // Payload size: collapse on timeout, restore on ack
  always_comb begin
    pay_next = pay_size;
    if (s1.cmd == lcrc_pkg::CMD_TIMEOUT) begin
      pay_next = cfg_min_pkt;
    end else if (ack_go && (pay_size < cfg_default_pkt)) begin
      pay_next = cfg_default_pkt;
    end
  end

  always_comb begin
    s2_next.info.cmd       = s1.cmd;
    s2_next.info.ack_go    = ack_go;
    s2_next.info.rtt_taken = rtt_take;
    s2_next.info.srtt      = srtt_next;
    s2_next.info.rttvar    = rttvar_next;
    s2_next.info.pay       = pay_next;
    s2_next.info.base0     = (base_delay == '0);
    s2_next.info.base      = base_next;
    s2_next.prod           = lcrc_pkg::PROD_W'(off_q) * lcrc_pkg::PROD_W'(s1.freed);
    s2_next.inflight       = s1.inflight;
    s2_next.peer           = s1.peer;
  end

  // ---------------------------------------------------------------- stage 2
  logic [lcrc_pkg::RPROD_W-1:0] rprod;
  logic [RW+2:0]                rto_sum, rto_lo;

  assign rprod = lcrc_pkg::RPROD_W'(s2.prod[lcrc_pkg::PROD_W-1:lcrc_pkg::DIV_SHIFT]) *
                 lcrc_pkg::RPROD_W'(lcrc_pkg::RECIP);

  // Candidate RTO from the updated estimators; the maximum clamp wins
  assign rto_sum = (RW+3)'(s2.info.srtt) + (RW+3)'({s2.info.rttvar, 2'b00});
  assign rto_lo  = (rto_sum < (RW+3)'(cfg_rto_min)) ? (RW+3)'(cfg_rto_min) : rto_sum;

  always_comb begin
    s3_next.info     = s2.info;
    s3_next.pq       = s2.prod[lcrc_pkg::PROD_W-1:lcrc_pkg::DIV_SHIFT];
    s3_next.q0       = rprod[lcrc_pkg::RECIP_SHIFT+FW-1:lcrc_pkg::RECIP_SHIFT];
    s3_next.rto_cand = (rto_lo > (RW+3)'(cfg_rto_max)) ? cfg_rto_max : rto_lo[RW-1:0];
    s3_next.xneed    = XW'(s2.inflight) + XW'(s2.info.pay);
    s3_next.peer_ok  = (XW'(s2.peer) >= (XW'(s2.inflight) + XW'(s2.info.pay)));
  end

  // ---------------------------------------------------------------- stage 3
  logic [lcrc_pkg::PQ_W-1:0] rem;

  // Correct the reciprocal estimate, which is low by at most one
  assign rem = s3.pq - lcrc_pkg::PQ_W'(s3.q0) * lcrc_pkg::PQ_W'(lcrc_pkg::DIV_ODD);

  always_comb begin
    s4_next.info     = s3.info;
    s4_next.quot     = (rem >= lcrc_pkg::PQ_W'(lcrc_pkg::DIV_ODD)) ? (s3.q0 + FW'(1)) : s3.q0;
    s4_next.rto_cand = s3.rto_cand;
    s4_next.xneed    = s3.xneed;
    s4_next.peer_ok  = s3.peer_ok;
  end

  // ---------------------------------------------------------------- stage 4
  logic [TW+1:0] grow, gmax;
  logic [TW-1:0] gsat, half, loss_w, cong_next;
  logic [RW:0]   rto_dbl;
  logic [RW-1:0] rto_to, rto_next;
  logic          may_next;

  // Grow: add quotient, plus a packet while there is no base, floor at one payload, saturate
  assign grow = (TW+2)'(cong_window) + (TW+2)'(s4.quot) +
                (s4.info.base0 ? (TW+2)'(s4.info.pay) : '0);
  assign gmax = (grow < (TW+2)'(s4.info.pay)) ? (TW+2)'(s4.info.pay) : grow;
  assign gsat = (gmax > (TW+2)'({TW{1'b1}})) ? {TW{1'b1}} : gmax[TW-1:0];

  assign half   = {1'b0, cong_window[TW-1:1]};
  assign loss_w = (half < TW'(s4.info.pay)) ? TW'(s4.info.pay) : half;

  always_comb begin
    case (s4.info.cmd)
      lcrc_pkg::CMD_ACK:     cong_next = s4.info.ack_go ? gsat : cong_window;
      lcrc_pkg::CMD_LOSS:    cong_next = loss_w;
      lcrc_pkg::CMD_TIMEOUT: cong_next = TW'(s4.info.pay);
      default:               cong_next = cong_window;
    endcase
  end

  // Back off the timer on timeout, load the computed value on a taken sample
  assign rto_dbl = {rto_value, 1'b0};
  assign rto_to  = (rto_dbl > (RW+1)'(cfg_rto_max)) ? cfg_rto_max : rto_dbl[RW-1:0];

  always_comb begin
    rto_next = rto_value;
    if (s4.info.rtt_taken) begin
      rto_next = s4.rto_cand;
    end else if (s4.info.cmd == lcrc_pkg::CMD_TIMEOUT) begin
      rto_next = rto_to;
    end
  end

  assign may_next = s4.peer_ok && (XW'(cong_next) >= s4.xneed);

  // ---------------------------------------------------------------- registers
  // Configuration writes; the initial RTO only matters at reset, where the
  // default is reloaded, so a written value never reaches the timer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base_window <= lcrc_pkg::DEF_BASE_WINDOW;
      cfg_default_pkt <= lcrc_pkg::DEF_PACKET;
      cfg_min_pkt     <= lcrc_pkg::DEF_MIN_PACKET;
      cfg_rto_min     <= lcrc_pkg::DEF_RTO_MIN;
      cfg_rto_max     <= lcrc_pkg::DEF_RTO_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        lcrc_pkg::CFG_BASE_WINDOW: cfg_base_window <= cfg_data[TW-1:0];
        lcrc_pkg::CFG_DEFAULT_PKT: cfg_default_pkt <= cfg_data[PW-1:0];
        lcrc_pkg::CFG_MIN_PKT:     cfg_min_pkt     <= cfg_data[PW-1:0];
        lcrc_pkg::CFG_RTO_MIN:     cfg_rto_min     <= cfg_data[RW-1:0];
        lcrc_pkg::CFG_RTO_MAX:     cfg_rto_max     <= cfg_data[RW-1:0];
        lcrc_pkg::CFG_INITIAL_RTO: ;
        default: ;
      endcase
    end
  end

  // Valids, connection state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      out_valid   <= 1'b0;
      last_delay  <= '0;
      base_delay  <= '0;
      base_time   <= '0;
      off_q       <= lcrc_pkg::TARGET_US;
      srtt        <= '0;
      rttvar      <= '0;
      pay_size    <= lcrc_pkg::DEF_PACKET;
      cong_window <= lcrc_pkg::RESET_WINDOW;
      rto_value   <= lcrc_pkg::DEF_INITIAL_RTO;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
      if (free_out) out_valid <= v4;
      // front state advances as an item leaves stage 1
      if (go1) begin
        last_delay <= last_next;
        base_delay <= base_next;
        base_time  <= base_time_next;
        off_q      <= off_next;
        srtt       <= srtt_next;
        rttvar     <= rttvar_next;
        pay_size   <= pay_next;
      end
      // back state advances as an item enters the output register
      if (go4) begin
        cong_window <= cong_next;
        rto_value   <= rto_next;
      end
    end
  end

  // Stage payloads and result fields
  always_ff @(posedge clk) begin
    if (free1) begin
      s1.cmd      <= lcrc_pkg::cmd_t'(cmd);
      s1.now      <= now_us;
      s1.dsample  <= delay_sample_us;
      s1.freed    <= freed_bytes;
      s1.rvalid   <= rtt_valid;
      s1.rsample  <= rtt_sample_us;
      s1.inflight <= in_flight_bytes;
      s1.peer     <= peer_window;
    end
    if (free2) s2 <= s2_next;
    if (free3) s3 <= s3_next;
    if (free4) s4 <= s4_next;
    if (free_out) begin
      window_bytes     <= cong_next;
      payload_size     <= s4.info.pay;
      rto_us           <= rto_next;
      smoothed_rtt_us  <= s4.info.srtt;
      rtt_deviation_us <= s4.info.rttvar;
      base_delay_us    <= s4.info.base;
      may_send         <= may_next;
    end
  end

  // ---------------------------------------------------------------- checks
  // Distance below target never exceeds the target itself
  a_off_bound: assert property (@(posedge clk) disable iff (rst)
    off_q <= lcrc_pkg::TARGET_US)
    else $error("growth offset above target");

  // Reciprocal estimate is never more than one below the true quotient
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (rem < (lcrc_pkg::PQ_W'(lcrc_pkg::DIV_ODD) << 1)))
    else $error("quotient correction out of range");

  // A timeout leaves the window at exactly one payload
  a_timeout_win: assert property (@(posedge clk) disable iff (rst)
    (go4 && (s4.info.cmd == lcrc_pkg::CMD_TIMEOUT)) |=>
      (window_bytes == TW'(payload_size)))
    else $error("timeout window mismatch");

endmodule
